[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the neighbor edge weight block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion lbl failed");

// never true while out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  `ASSERT_CLK(lbl, clk, rstn, !(expr))

`endif

[rtl/nwe_pkg.sv]
// Types, constants and helper functions of the neighbor edge weight block.
// No dependencies.
`default_nettype none
package nwe_pkg;

  localparam int unsigned REG_ROW_WIDTH = 0;
  localparam int unsigned REG_BETA      = 1;
  localparam int unsigned REG_GAMMA     = 2;

  localparam int unsigned D2W  = 18;
  localparam int unsigned WGTW = 24;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
  localparam logic [3:0]  LAST_TERM     = 4'd12;

  localparam logic [1:0] LANE_LEFT    = 2'd0;
  localparam logic [1:0] LANE_UPLEFT  = 2'd1;
  localparam logic [1:0] LANE_UP      = 2'd2;
  localparam logic [1:0] LANE_UPRIGHT = 2'd3;

  typedef struct packed {
    logic [3:0][D2W-1:0] d2;
    logic [3:0]          mask;
  } job_t;

  function automatic logic [D2W-1:0] dist2(input logic [31:0] a, input logic [31:0] b);
    logic [D2W-1:0] s;
    logic [7:0]     d;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      d = (a[8*i +: 8] > b[8*i +: 8]) ? (a[8*i +: 8] - b[8*i +: 8])
                                      : (b[8*i +: 8] - a[8*i +: 8]);
      s = s + D2W'(d) * D2W'(d);
    end
    return s;
  endfunction

  // floor(2^32 / k)
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/neighbor_edge_weights.sv]
// Neighbor edge weights: for each pixel beat, four Q16.8 edge weights to the left,
// upper-left, upper and upper-right neighbors. The front end does two line-store reads
// and a write per pixel; the engine then runs each lane through the exp series unit
// (11 series terms of multiply, reciprocal multiply and check, four squarings), and
// skips the series for masked or saturated lanes, so the single shared series unit
// sets the pixel rate.
// Depends on nwe_pkg, nwe_front, nwe_fifo, nwe_back.
`default_nettype none
module neighbor_edge_weights import nwe_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // chan0, chan1, chan2, chan3
  input  wire logic        s_axis_tuser,   // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata    // weight_left, weight_upleft, weight_up, weight_upright
);
  logic [11:0] row_width_q;
  logic [31:0] beta_q;
  logic [23:0] gamma_q;
  logic        push, full, pop, empty;
  job_t        job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 12'd640;
      beta_q      <= 32'd4294967;
      gamma_q     <= 24'd12800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        2'(REG_ROW_WIDTH): row_width_q <= cfg_data_i[11:0];
        2'(REG_BETA):      beta_q      <= cfg_data_i;
        2'(REG_GAMMA):     gamma_q     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  nwe_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_width_i   (row_width_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .job_o         (job_in),
    .full_i        (full)
  );

  nwe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (job_out),
    .empty_o (empty)
  );

  nwe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beta_i        (beta_q),
    .gamma_i       (gamma_q),
    .job_i         (job_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );
endmodule
`default_nettype wire

[rtl/nwe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nwe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/nwe_fifo.sv]
// Two-entry job queue between the pixel front end and the weight engine.
// Depends on nwe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module nwe_fifo import nwe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      din_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      dout_o,
  output logic      empty_o
);
  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, cnt_q == 2'd3)
endmodule
`default_nettype wire

[rtl/nwe_front.sv]
// Pixel front end: tracks row position, reads the line store, forms the
// squared distances to the four neighbors and queues them. Depends on nwe_pkg, nwe_ram.
`default_nettype none
module nwe_front import nwe_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [11:0] row_width_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // chan0, chan1, chan2, chan3
  input  wire logic        s_axis_tuser,   // frame_start
  output logic             push_o,
  output job_t             job_o,
  input  wire logic        full_i
);
  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (CW > 12) ? CW + 1 : 13;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP   = 2'd1;
  localparam logic [1:0] S_UR   = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [AW-1:0]   col_q, col_d, x_q, x_d;
  logic            first_q, first_d;
  logic [31:0]     cur_q, prev_q, hold_q, up_q;
  logic            left_q, hup_q, hur_q;
  logic            accept;
  logic [CMPW-1:0] w, rw_ext, col_ext, x1_ext;
  logic [AW-1:0]   raddr;
  logic [31:0]     rdata;
  logic            fs_first;
  logic [AW-1:0]   fs_col;

  assign rw_ext = CMPW'(row_width_i);
  always_comb begin
    if (rw_ext == '0) begin
      w = CMPW'(1);
    end else if (rw_ext > CMPW'(MAX_WIDTH)) begin
      w = CMPW'(MAX_WIDTH);
    end else begin
      w = rw_ext;
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    fs_col   = s_axis_tuser ? '0 : col_q;
    fs_first = s_axis_tuser ? 1'b1 : first_q;
    col_ext  = CMPW'(fs_col);
    first_d  = first_q;
    x_d      = x_q;
    col_d    = col_q;
    if (accept) begin
      x_d     = fs_col;
      first_d = fs_first;
      if (col_ext >= w) begin
        x_d     = '0;
        first_d = 1'b0;
      end
      x1_ext = CMPW'(x_d) + CMPW'(1);
      col_d  = x_d + AW'(1);
      if (x1_ext >= w) begin
        col_d   = '0;
        first_d = 1'b0;
      end
    end else begin
      x1_ext = CMPW'(x_q) + CMPW'(1);
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (accept) st_d = S_UP;
      S_UP:    st_d = S_UR;
      S_UR:    if (!full_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign raddr  = (st_q == S_IDLE) ? x_d : (x_q + AW'(1));
  assign push_o = (st_q == S_UR) && !full_i;

  always_comb begin
    job_o.d2[LANE_LEFT]    = dist2(cur_q, prev_q);
    job_o.d2[LANE_UPLEFT]  = dist2(cur_q, hold_q);
    job_o.d2[LANE_UP]      = dist2(cur_q, up_q);
    job_o.d2[LANE_UPRIGHT] = dist2(cur_q, rdata);
    job_o.mask[LANE_LEFT]    = left_q;
    job_o.mask[LANE_UPLEFT]  = left_q && hup_q;
    job_o.mask[LANE_UP]      = hup_q;
    job_o.mask[LANE_UPRIGHT] = hur_q;
  end

  nwe_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (x_q),
    .wdata_i (cur_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      col_q   <= '0;
      first_q <= 1'b1;
      prev_q  <= '0;
      hold_q  <= '0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        col_q   <= col_d;
        first_q <= first_d;
      end
      if (push_o) begin
        prev_q <= cur_q;
        hold_q <= up_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_d;
      cur_q  <= s_axis_tdata;
      left_q <= (x_d != '0);
      hup_q  <= !fs_first || (col_ext >= w);
      hur_q  <= (!fs_first || (col_ext >= w)) && (x1_ext < w);
    end
    if (st_q == S_UP) begin
      up_q <= rdata;
    end
  end
endmodule
`default_nettype wire

[rtl/nwe_back.sv]
// Weight engine: per neighbor lane forms exp(-beta*d2) by a shared series unit, scales
// by gamma (and 1/sqrt(2) for diagonals) and registers the result beat. Depends on nwe_pkg.
`default_nettype none
module nwe_back import nwe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] beta_i,
  input  wire logic [23:0] gamma_i,
  input  job_t             job_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata   // weight_left, weight_upleft, weight_up, weight_upright
);
  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_MX   = 4'd1;
  localparam logic [3:0] B_CHK  = 4'd2;
  localparam logic [3:0] B_T1   = 4'd3;
  localparam logic [3:0] B_T2   = 4'd4;
  localparam logic [3:0] B_T3   = 4'd5;
  localparam logic [3:0] B_SQ   = 4'd6;
  localparam logic [3:0] B_RND  = 4'd7;
  localparam logic [3:0] B_G    = 4'd8;
  localparam logic [3:0] B_D    = 4'd9;
  localparam logic [3:0] B_W    = 4'd10;
  localparam logic [3:0] B_OUT  = 4'd11;

  localparam logic [49:0] X_LIMIT = 50'd12 << 32;

  logic [3:0]  st_q;
  logic [1:0]  lane_q, sq_q;
  logic [3:0]  k_q;
  logic [49:0] x_q;
  logic [31:0] y, term_q, p_q, q_q;
  logic [33:0] pos_q, neg_q;
  logic [32:0] e_q;
  logic [16:0] e16_q;
  logic [40:0] g_q;
  logic [56:0] gd_q;
  logic [23:0] w_q [4];
  logic        out_v_q;
  logic [35:0] rem;
  logic [65:0] esq;
  logic [33:0] erd;
  logic        diag;

  assign y     = x_q[35:4];
  assign rem   = {4'd0, p_q} - (q_q * k_q);
  assign esq   = e_q * e_q;
  assign erd   = {1'b0, e_q} + 34'd32768;
  assign diag  = (lane_q == LANE_UPLEFT) || (lane_q == LANE_UPRIGHT);
  assign pop_o = (st_q == B_OUT) && (!out_v_q || m_axis_tready);
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      out_v_q <= 1'b0;
      lane_q  <= '0;
    end else begin
      if (pop_o) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: if (!empty_i) begin
          lane_q <= LANE_LEFT;
          st_q   <= B_MX;
        end
        B_MX:  st_q <= B_CHK;
        B_CHK: begin
          if (!job_i.mask[lane_q] || (x_q >= X_LIMIT) || (y == '0)) begin
            st_q <= B_G;
          end else begin
            st_q <= B_T1;
          end
        end
        B_T1: st_q <= B_T2;
        B_T2: st_q <= B_T3;
        B_T3: if (rem < 36'(k_q)) begin
          st_q <= (k_q == LAST_TERM) ? B_SQ : B_T1;
        end
        B_SQ:  if (sq_q == 2'd3) st_q <= B_RND;
        B_RND: st_q <= B_G;
        B_G:   st_q <= B_D;
        B_D:   st_q <= diag ? B_W : ((lane_q == LANE_UPRIGHT) ? B_OUT : B_MX);
        B_W: begin
          st_q <= (lane_q == LANE_UPRIGHT) ? B_OUT : B_MX;
        end
        B_OUT: if (!out_v_q || m_axis_tready) begin
          st_q <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
      if ((st_q == B_W) || ((st_q == B_D) && !diag)) begin
        lane_q <= lane_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_MX: x_q <= beta_i * job_i.d2[lane_q];
      B_CHK: begin
        if (!job_i.mask[lane_q] || (x_q >= X_LIMIT)) begin
          e16_q <= '0;
        end else if (y == '0) begin
          e16_q <= 17'h10000;
        end
        term_q <= y;
        pos_q  <= 34'h1_0000_0000;
        neg_q  <= {2'b0, y};
        k_q    <= 4'd2;
      end
      B_T1: p_q <= 32'((64'(term_q) * 64'(y)) >> 32);
      B_T2: q_q <= 32'((64'(p_q) * 64'(recip(k_q))) >> 32);
      B_T3: begin
        if (rem >= 36'(k_q)) begin
          q_q <= q_q + 32'd1;
        end else begin
          term_q <= q_q;
          k_q    <= k_q + 4'd1;
          if (k_q[0]) neg_q <= neg_q + 34'(q_q);
          else        pos_q <= pos_q + 34'(q_q);
          if (k_q == LAST_TERM) begin
            e_q  <= 33'(pos_q + 34'(q_q) - neg_q);
            sq_q <= 2'd0;
          end
        end
      end
      B_SQ: begin
        e_q  <= esq[64:32];
        sq_q <= sq_q + 2'd1;
      end
      B_RND: e16_q <= erd[32:16];
      B_G:   g_q   <= gamma_i * e16_q;
      B_D: begin
        if (diag) gd_q <= g_q * INV_SQRT2_Q16;
        else      w_q[lane_q] <= g_q[39:16];
      end
      B_W: w_q[lane_q] <= gd_q[55:32];
      B_OUT: if (!out_v_q || m_axis_tready) begin
        m_axis_tdata <= {w_q[3], w_q[2], w_q[1], w_q[0]};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
